// ----- rtl/assert_macros.svh -----
// Assertion helpers used by tdq_ctrl. Clock clk and reset rst_n are implied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define CHK_ALWAYS(lbl, expr)
`define CHK_IMPLY(lbl, ante, cons)
`endif
`endif

// ----- rtl/tdq_pkg.sv -----
`default_nettype none
package tdq_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int EW = 160;

  typedef enum logic [1:0] {
    OP_REG  = 2'd0,
    OP_KILL = 2'd1,
    OP_EXP  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_RESOURCE = 2'd1,
    ST_INVALID_ID  = 2'd2,
    ST_EMPTY       = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] now_us;
    logic [63:0] interval_us;
    logic        repeat_req;
    logic [30:0] target_id;
  } tdq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] assigned_id;
    logic [30:0] expired_id;
    logic [63:0] next_deadline;
    logic        next_valid;
    logic [4:0]  timer_count;
  } tdq_out_t;

  typedef struct packed {
    logic [63:0] deadline;
    logic [63:0] period;
    logic [30:0] id;
    logic        rep;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/tdq_ram.sv -----
`default_nettype none
module tdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tdq_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
module tdq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tdq_pkg::tdq_in_t  in_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output tdq_pkg::tdq_out_t      res_data,
  output logic                   ram_rd_en,
  output logic [tdq_pkg::AW-1:0] ram_rd_addr,
  input  wire tdq_pkg::entry_t   ram_rd_data,
  output logic                   ram_wr_en,
  output logic [tdq_pkg::AW-1:0] ram_wr_addr,
  output tdq_pkg::entry_t        ram_wr_data
);
  import tdq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_INSS = 8'b00000010,
    S_INS  = 8'b00000100,
    S_INSW = 8'b00001000,
    S_KILL = 8'b00010000,
    S_EXP0 = 8'b00100000,
    S_HEAD = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [30:0]     target_r, target_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [30:0]     seed_r, seed_nxt;
  entry_t          ent_r, ent_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            found_r, found_nxt;
  status_t         status_r, status_nxt;
  logic [30:0]     asg_r, asg_nxt;
  logic [30:0]     exp_r, exp_nxt;
  logic [30:0]     seed_inc;
  logic [30:0]     seed_sum;
  logic            match;

  // Next id skips zero after the wrap.
  assign seed_sum = seed_r + 31'd1;
  assign seed_inc = (seed_sum == 31'd0) ? 31'd1 : seed_sum;
  assign match    = !found_r && (ram_rd_data.id == target_r);

  // Sequencer: each step reads at most one entry and writes at most one back.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    target_nxt  = target_r;
    cnt_nxt     = cnt_r;
    seed_nxt    = seed_r;
    ent_nxt     = ent_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    asg_nxt     = asg_r;
    exp_nxt     = exp_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = ent_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_data.opcode;
          target_nxt = in_data.target_id;
          asg_nxt    = '0;
          exp_nxt    = '0;
          status_nxt = ST_OK;
          case (in_data.opcode)
            OP_REG: begin
              if (cnt_r >= CW'(MAX_TIMERS)) begin
                status_nxt = ST_NO_RESOURCE;
                state_nxt  = S_HEAD;
              end else begin
                seed_nxt         = seed_inc;
                asg_nxt          = seed_inc;
                ent_nxt.deadline = in_data.now_us + in_data.interval_us;
                ent_nxt.period   = in_data.interval_us;
                ent_nxt.id       = seed_inc;
                ent_nxt.rep      = in_data.repeat_req;
                state_nxt        = S_INSS;
              end
            end
            OP_KILL: begin
              if (cnt_r == '0) begin
                status_nxt = ST_INVALID_ID;
                state_nxt  = S_HEAD;
              end else begin
                ram_rd_en = 1'b1;
                idx_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = S_KILL;
              end
            end
            OP_EXP: begin
              if (cnt_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_HEAD;
              end else begin
                ram_rd_en = 1'b1;
                state_nxt = S_EXP0;
              end
            end
            default: begin
              state_nxt = S_HEAD;
            end
          endcase
        end
      end
      S_INSS: begin
        // Start the insertion walk from the tail.
        if (cnt_r == '0) begin
          ram_wr_en = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_HEAD;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(cnt_r - 1'b1);
          idx_nxt     = AW'(cnt_r - 1'b1);
          state_nxt   = S_INS;
        end
      end
      S_INS: begin
        // Later deadlines move up one place; equal ones stay ahead.
        ram_wr_en   = 1'b1;
        ram_wr_addr = AW'(idx_r + 1'b1);
        if (ram_rd_data.deadline > ent_r.deadline) begin
          ram_wr_data = ram_rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INSW;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_r - 1'b1;
            idx_nxt     = idx_r - 1'b1;
          end
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_INSW: begin
        ram_wr_en = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_HEAD;
      end
      S_KILL: begin
        // Search for the id (an expire starts past the head), then close the gap behind it.
        if (found_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_r - 1'b1;
          ram_wr_data = ram_rd_data;
        end
        found_nxt = found_r | match;
        if (CW'(idx_r) == cnt_r - 1'b1) begin
          if (found_r | match) begin
            cnt_nxt = cnt_r - 1'b1;
            if (op_r == OP_EXP && ent_r.rep) begin
              state_nxt = S_INSS;
            end else begin
              state_nxt = S_HEAD;
            end
          end else begin
            status_nxt = ST_INVALID_ID;
            state_nxt  = S_HEAD;
          end
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(idx_r + 1'b1);
          idx_nxt     = AW'(idx_r + 1'b1);
        end
      end
      S_EXP0: begin
        // Head entry arrives; keep it for a possible re-arm.
        ent_nxt.deadline = ram_rd_data.deadline + ram_rd_data.period;
        ent_nxt.period   = ram_rd_data.period;
        ent_nxt.id       = ram_rd_data.id;
        ent_nxt.rep      = ram_rd_data.rep;
        exp_nxt          = ram_rd_data.id;
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = '0;
          state_nxt = ram_rd_data.rep ? S_INSS : S_HEAD;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(1);
          idx_nxt     = AW'(1);
          found_nxt   = 1'b1;
          state_nxt   = S_KILL;
        end
      end
      S_HEAD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result fields; the head read stays stable while waiting.
  always_comb begin
    res_data.status        = status_r;
    res_data.assigned_id   = asg_r;
    res_data.expired_id    = exp_r;
    res_data.next_valid    = (cnt_r != '0);
    res_data.next_deadline = (cnt_r != '0) ? ram_rd_data.deadline : 64'd0;
    res_data.timer_count   = 5'(cnt_r);
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      seed_r  <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      seed_r  <= seed_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    target_r <= target_nxt;
    ent_r    <= ent_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    asg_r    <= asg_nxt;
    exp_r    <= exp_nxt;
  end

  `CHK_ALWAYS(a_cnt_range, cnt_r <= CW'(MAX_TIMERS))
  `CHK_ALWAYS(a_no_rw_clash, !(ram_rd_en && ram_wr_en && ram_rd_addr == ram_wr_addr))
  `CHK_IMPLY(a_full_status, res_valid && status_r == ST_NO_RESOURCE, cnt_r == CW'(MAX_TIMERS))

endmodule
`default_nettype wire

// ----- rtl/timer_deadline_queue.sv -----
// Sorted timer queue. One command enters on the in_ channel (opcode: register,
// kill or expire) and gives exactly one result on the out_ channel, with the
// status, the new or expired id, the count and the earliest deadline held.
// Entries live in one memory, kept in deadline order; a register, kill or
// expire walks it one entry per cycle through the read port and writes
// back through the write port. A repeating expire also runs the
// reinsertion walk after it removes the head.
// One command is worked on at a time; the next can be taken in the cycle
// after the previous result has moved into the output register.
// Reset empties the queue and restarts id numbering; no memory clear is run.
// If out_ready stays low the result holds in the output register and the
// block stops after the next command is done.
`default_nettype none
module timer_deadline_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tdq_pkg::tdq_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tdq_pkg::tdq_out_t      out_data
);
  import tdq_pkg::*;

  logic          res_valid;
  logic          res_ready;
  tdq_out_t      res_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          out_valid_r;
  tdq_out_t      out_data_r;

  tdq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .ram_rd_en   (rd_en),
    .ram_rd_addr (rd_addr),
    .ram_rd_data (rd_data),
    .ram_wr_en   (wr_en),
    .ram_wr_addr (wr_addr),
    .ram_wr_data (wr_data)
  );

  tdq_ram #(.WIDTH(EW), .DEPTH(MAX_TIMERS)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Output register decouples the sequencer from the receiver.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- bench/timer_deadline_queue_test.sv -----
`timescale 1ns / 1ps
module timer_deadline_queue_test;
  import tdq_pkg::*;

  // Predicts results of the sorted timer queue and checks them in order.
  class deadline_queue_scoreboard;
    logic [63:0] dl_q[$];
    logic [63:0] per_q[$];
    logic [30:0] id_q[$];
    logic        rep_q[$];
    logic [30:0] next_id;
    tdq_out_t    pending[$];
    int          errors;

    function void clear();
      dl_q.delete(); per_q.delete(); id_q.delete(); rep_q.delete();
      next_id = '0;
      pending.delete();
      errors = 0;
    endfunction

    function int held();
      return dl_q.size();
    endfunction

    // Equal deadlines keep their order of insertion.
    function void insert_sorted(logic [63:0] dl, logic [63:0] per, logic [30:0] id,
                                logic rep);
      int pos;
      pos = 0;
      while (pos < dl_q.size() && dl_q[pos] <= dl) pos++;
      dl_q.insert(pos, dl);
      per_q.insert(pos, per);
      id_q.insert(pos, id);
      rep_q.insert(pos, rep);
    endfunction

    function void drop_at(int pos);
      dl_q.delete(pos); per_q.delete(pos); id_q.delete(pos); rep_q.delete(pos);
    endfunction

    // Note an accepted command and queue its expected result.
    function void note_command(tdq_in_t cmd);
      tdq_out_t r;
      logic [63:0] dl, per;
      logic [30:0] id;
      logic rep;
      r = '0;
      r.status = ST_OK;
      case (op_t'(cmd.opcode))
        OP_REG: begin
          if (held() >= MAX_TIMERS) begin
            r.status = ST_NO_RESOURCE;
          end else begin
            next_id = next_id + 31'd1;
            if (next_id == '0) next_id = 31'd1;
            insert_sorted(cmd.now_us + cmd.interval_us, cmd.interval_us, next_id,
                          cmd.repeat_req);
            r.assigned_id = next_id;
          end
        end
        OP_KILL: begin
          r.status = ST_INVALID_ID;
          for (int i = 0; i < held(); i++) begin
            if (id_q[i] == cmd.target_id) begin
              drop_at(i);
              r.status = ST_OK;
              break;
            end
          end
        end
        OP_EXP: begin
          if (held() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            dl = dl_q[0]; per = per_q[0]; id = id_q[0]; rep = rep_q[0];
            drop_at(0);
            if (rep) insert_sorted(dl + per, per, id, 1'b1);
            r.expired_id = id;
          end
        end
        default: ;
      endcase
      r.next_valid = (held() > 0);
      r.next_deadline = (held() > 0) ? dl_q[0] : 64'd0;
      r.timer_count = 5'(held());
      pending.push_back(r);
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(tdq_out_t got);
      tdq_out_t e;
      if (pending.size() == 0) begin
        $error("result with no expectation waiting: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
      if (got.assigned_id !== e.assigned_id) begin
        $error("assigned_id expected %0d actual %0d", e.assigned_id, got.assigned_id);
        errors++;
      end
      if (got.expired_id !== e.expired_id) begin
        $error("expired_id expected %0d actual %0d", e.expired_id, got.expired_id);
        errors++;
      end
      if (got.next_deadline !== e.next_deadline) begin
        $error("next_deadline expected %h actual %h", e.next_deadline,
               got.next_deadline);
        errors++;
      end
      if (got.next_valid !== e.next_valid) begin
        $error("next_valid expected %0d actual %0d", e.next_valid, got.next_valid);
        errors++;
      end
      if (got.timer_count !== e.timer_count) begin
        $error("timer_count expected %0d actual %0d", e.timer_count, got.timer_count);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tdq_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tdq_out_t out_data;

  deadline_queue_scoreboard sb;
  bit calm;
  bit hold_off;
  int idle_cycles;

  timer_deadline_queue uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Accepted transactions on both channels, plus the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_command(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && sb.pending.size() == 0)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none when calm.
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        for (int i = 0; i < 300; i++) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 3);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one command and wait for its acceptance.
  task automatic send_command(logic [1:0] op, logic [63:0] now, logic [63:0] per,
                              logic rep, logic [30:0] tid);
    tdq_in_t c;
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 3);
      repeat (n) @(negedge clk);
    end
    c.opcode = op; c.now_us = now; c.interval_us = per;
    c.repeat_req = rep; c.target_id = tid;
    in_data <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly a held id, sometimes a random, zero or not yet assigned one.
  function automatic logic [30:0] pick_id();
    int k;
    k = $urandom_range(0, 9);
    if (sb.held() > 0 && k < 7) return sb.id_q[$urandom_range(0, sb.held() - 1)];
    if (k == 7) return '0;
    if (k == 8) return sb.next_id + 31'd1;
    return 31'($urandom());
  endfunction

  // Random command weighted to keep the queue partly full.
  task automatic random_command();
    int k;
    logic [63:0] now, per;
    k = $urandom_range(0, 19);
    now = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 5000));
    per = ($urandom_range(0, 7) == 0) ? rand64() : 64'($urandom_range(0, 300));
    if (k < 8)
      send_command(OP_REG, now, per, 1'($urandom_range(0, 1)), 31'(rand64()));
    else if (k < 12)
      send_command(OP_KILL, rand64(), rand64(), 1'($urandom_range(0, 1)), pick_id());
    else if (k < 19)
      send_command(OP_EXP, rand64(), rand64(), 1'($urandom_range(0, 1)),
                   31'($urandom()));
    else
      send_command(OP_NOP, rand64(), rand64(), 1'($urandom_range(0, 1)),
                   31'($urandom()));
  endtask

  initial begin
    int cycles;
    sb = new();
    sb.clear();
    calm = 1'b0;
    hold_off = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty expire, unknown kill, extremes, wrap, equal deadlines, fill.
    send_command(OP_EXP, '0, '0, 1'b0, '0);
    send_command(OP_KILL, '0, '0, 1'b0, '0);
    send_command(OP_NOP, '1, '1, 1'b1, '1);
    send_command(OP_REG, '1, 64'd2, 1'b1, '1);
    send_command(OP_REG, 64'd5, '0, 1'b0, '0);
    send_command(OP_REG, 64'd3, 64'd2, 1'b1, '0);
    send_command(OP_REG, '1, '1, 1'b0, '0);
    send_command(OP_KILL, '0, '0, 1'b0, 31'd2);
    send_command(OP_KILL, '0, '0, 1'b0, 31'h7fffffff);
    send_command(OP_EXP, '0, '0, 1'b0, '0);
    send_command(OP_EXP, '0, '0, 1'b0, '0);
    for (int i = 0; i < 16; i++)
      send_command(OP_REG, 64'd100, 64'(i % 3), i[0], '0);
    send_command(OP_REG, 64'd1, 64'd1, 1'b0, '0);
    send_command(OP_EXP, '0, '0, 1'b0, '0);

    // Long receiver hold-off while commands keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) random_command();

    for (int i = 0; i < 700; i++) random_command();
    calm = 1'b1;
    for (int i = 0; i < 100; i++) random_command();
    in_valid <= 1'b0;

    cycles = 0;
    while (sb.pending.size() != 0 && cycles < 20000) begin
      @(negedge clk);
      cycles++;
    end
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tdq_pkg.sv
rtl/tdq_ram.sv
rtl/tdq_ctrl.sv
rtl/timer_deadline_queue.sv
bench/timer_deadline_queue_test.sv
